// File: rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/s9wp_pkg.sv
`timescale 1ns / 1ps
package s9wp_pkg;
    localparam int DATA_BITS_DEF = 28;
    localparam int NUM_LAYOUTS   = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_SHIFT,
        ST_OUT
    } state_t;

    // field width for layout lay, field i
    function automatic logic [4:0] field_width(input logic [3:0] lay, input logic [4:0] i);
        logic [4:0] w;
        unique case (lay)
            4'd0: w = 5'd1;
            4'd1: w = 5'd2;
            4'd2: w = (i == 5'd8) ? 5'd4 : 5'd3;
            4'd3: w = 5'd4;
            4'd4: w = (i >= 5'd2) ? 5'd6 : 5'd5;
            4'd5: w = 5'd7;
            4'd6: w = (i == 5'd2) ? 5'd10 : 5'd9;
            4'd7: w = 5'd14;
            default: w = 5'd28;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] layout_count(input logic [3:0] lay);
        logic [4:0] n;
        unique case (lay)
            4'd0: n = 5'd28;
            4'd1: n = 5'd14;
            4'd2: n = 5'd9;
            4'd3: n = 5'd7;
            4'd4: n = 5'd5;
            4'd5: n = 5'd4;
            4'd6: n = 5'd3;
            4'd7: n = 5'd2;
            default: n = 5'd1;
        endcase
        return n;
    endfunction
endpackage

// File: rtl/simple9_word_packer.sv
`timescale 1ns / 1ps
// Simple-9 word packer on one shared compare/shift unit.
// Throughput: an item that forms no word frees the input the next cycle.
// Per word: a layout scan over the fields, emitting the fields of the chosen layout, shifting
// the values left in the buffer down, then loading the output register.
// Input stays busy until the item's last word is loaded; a flush repeats this per word.
// Reset: synchronous active-low aresetn clears state, the buffer count and m_tvalid.
`include "assert_macros.svh"
module simple9_word_packer #(
    parameter int DATA_BITS = s9wp_pkg::DATA_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tlast,   // list_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // packed_word[31:0], values_packed[36:32]
    output logic        m_tlast,   // final_word
    output logic        m_tuser    // value_too_wide
);
    localparam int DEPTH = DATA_BITS;

    logic [DATA_BITS-1:0] buf_mem [DEPTH];
    logic [4:0] count_reg, count_next;
    s9wp_pkg::state_t state_reg, state_next;
    logic [3:0] lay_reg, lay_next;
    logic [4:0] idx_reg, idx_next;
    logic [4:0] pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [4:0] used_reg, used_next;
    logic last_reg, last_next, wide_reg, wide_next;
    logic [31:0] out_word_reg; logic [4:0] out_used_reg; logic out_fin_reg;
    logic out_wide_reg;
    logic out_next_fin;
    logic [DATA_BITS-1:0] cur;
    logic [4:0] fw, lc;
    logic fits;
    logic take;

    // output register parts the sides: a waiting word does not block intake
    assign take = s_tvalid && s_tready;
    assign s_tready = (state_reg == s9wp_pkg::ST_IDLE);
    assign cur = (idx_reg < count_reg) ? buf_mem[idx_reg] : '0;
    assign fw = s9wp_pkg::field_width(lay_reg, idx_reg);
    assign lc = s9wp_pkg::layout_count(lay_reg);
    assign fits = ((cur >> fw) == '0);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg; lay_next = lay_reg; idx_next = idx_reg;
        pos_next = pos_reg; word_next = word_reg; used_next = used_reg;
        last_next = last_reg; wide_next = wide_reg; out_next_fin = 1'b0;
        unique case (state_reg)
            s9wp_pkg::ST_IDLE: begin
                if (take) begin
                    last_next = s_tlast;
                    wide_next = (s_tdata[31:DATA_BITS] != '0);
                    if (!wide_next) count_next = count_reg + 5'd1;
                    lay_next = '0; idx_next = '0;
                    if ((s_tlast && (count_next != '0))
                        || (count_next == 5'(DEPTH))) state_next = s9wp_pkg::ST_SCAN;
                    else if (wide_next) begin
                        word_next = '0; used_next = '0; state_next = s9wp_pkg::ST_OUT;
                    end
                end
            end
            s9wp_pkg::ST_SCAN: begin
                if (lay_reg == 4'(s9wp_pkg::NUM_LAYOUTS - 1) || idx_reg == lc) begin
                    idx_next = '0; pos_next = 5'(DATA_BITS);
                    word_next = {lay_reg, {DATA_BITS{1'b0}}};
                    state_next = s9wp_pkg::ST_EMIT;
                end else if (!fits) begin
                    lay_next = lay_reg + 4'd1; idx_next = '0;
                end else idx_next = idx_reg + 5'd1;
            end
            s9wp_pkg::ST_EMIT: begin
                if (idx_reg == lc) begin
                    used_next = (lc > count_reg) ? count_reg : lc;
                    idx_next = '0;
                    state_next = s9wp_pkg::ST_SHIFT;
                end else begin
                    pos_next = pos_reg - fw;
                    word_next = word_reg | (32'(cur) << (pos_reg - fw));
                    idx_next = idx_reg + 5'd1;
                end
            end
            s9wp_pkg::ST_SHIFT: begin
                if (5'(idx_reg + used_reg) >= count_reg) begin
                    count_next = count_reg - used_reg;
                    state_next = s9wp_pkg::ST_OUT;
                end else idx_next = idx_reg + 5'd1;
            end
            default: begin
                if (!m_tvalid) begin
                    lay_next = '0; idx_next = '0;
                    if (last_reg && count_reg != '0) state_next = s9wp_pkg::ST_SCAN;
                    else state_next = s9wp_pkg::ST_IDLE;
                end
            end
        endcase
        out_next_fin = !(last_reg && count_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (take && s_tdata[31:DATA_BITS] == '0 && count_reg < 5'(DEPTH))
            buf_mem[count_reg[4:0]] <= s_tdata[DATA_BITS-1:0];
        else if (state_reg == s9wp_pkg::ST_SHIFT && 5'(idx_reg + used_reg) < count_reg)
            buf_mem[idx_reg] <= buf_mem[5'(idx_reg + used_reg)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= s9wp_pkg::ST_IDLE; count_reg <= '0; m_tvalid <= 1'b0;
        end else begin
            state_reg <= state_next; count_reg <= count_next;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (state_reg == s9wp_pkg::ST_OUT && !m_tvalid) begin
                m_tvalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lay_reg <= lay_next; idx_reg <= idx_next; pos_reg <= pos_next;
        word_reg <= word_next; used_reg <= used_next;
        last_reg <= last_next; wide_reg <= wide_next;
        if (state_reg == s9wp_pkg::ST_OUT && !m_tvalid) begin
            out_word_reg <= word_reg; out_used_reg <= used_reg; out_fin_reg <= out_next_fin;
            out_wide_reg <= wide_reg;
        end
    end

    assign m_tdata = {3'b000, out_used_reg, out_word_reg};
    assign m_tlast = out_fin_reg;
    assign m_tuser = out_wide_reg;

    `ASSERT_IMPLIES(a_cnt_max, aclk, aresetn, 1'b1, count_reg <= 5'(DEPTH))
    `ASSERT_IMPLIES(a_no_take_busy, aclk, aresetn, state_reg != s9wp_pkg::ST_IDLE, !s_tready)
    `ASSERT_IMPLIES(a_used_max, aclk, aresetn, m_tvalid, out_used_reg <= 5'd28)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
endmodule

// File: dv/simple9_word_packer_tb.sv
`timescale 1ns / 1ps
module simple9_word_packer_tb;

    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  count;
        logic        too_wide;
        logic        final_flag;
    } packed_word_t;

    // Predicts the packed words and holds them until the block emits them.
    class word_scoreboard;
        logic [27:0]  held_vals[28];
        int unsigned  held_num;
        packed_word_t pending_words[$];
        int unsigned  error_count;

        function void clear();
            held_num = 0;
            pending_words.delete();
            error_count = 0;
        endfunction

        function logic [27:0] head_val(int unsigned i);
            return (i < held_num) ? held_vals[i] : 28'd0;
        endfunction

        static function int unsigned fields_in(int unsigned lay);
            int unsigned n[9] = '{28, 14, 9, 7, 5, 4, 3, 2, 1};
            return n[lay];
        endfunction

        static function int unsigned width_of(int unsigned lay, int unsigned i);
            int unsigned w[9] = '{1, 2, 3, 4, 5, 7, 9, 14, 28};
            if (lay == 2 && i == 8) return 4;
            if (lay == 4 && i >= 2) return 6;
            if (lay == 6 && i == 2) return 10;
            return w[lay];
        endfunction

        // Greedy layout pick: first code whose fields hold the leading values.
        function packed_word_t pack_head();
            packed_word_t r;
            int unsigned lay, i, n, pos;
            bit fits;
            for (lay = 0; lay < 8; lay++) begin
                fits = 1;
                for (i = 0; i < fields_in(lay); i++)
                    if ((head_val(i) >> width_of(lay, i)) != 0) fits = 0;
                if (fits) break;
            end
            r = '0;
            r.word[31:28] = lay[3:0];
            pos = 28;
            for (i = 0; i < fields_in(lay); i++) begin
                pos -= width_of(lay, i);
                r.word = r.word | (32'(head_val(i)) << pos);
            end
            n = fields_in(lay);
            if (n > held_num) n = held_num;
            for (i = 0; i + n < held_num; i++) held_vals[i] = held_vals[i + n];
            held_num -= n;
            r.count = n[4:0];
            return r;
        endfunction

        function void note_item(logic [31:0] value, logic list_end);
            packed_word_t step_words[$];
            packed_word_t r;
            bit wide;
            wide = value[31:28] != 0;
            if (!wide && held_num < 28) begin
                held_vals[held_num] = value[27:0];
                held_num++;
            end
            if (list_end) begin
                while (held_num > 0) step_words.push_back(pack_head());
            end else if (held_num >= 28) begin
                step_words.push_back(pack_head());
            end
            if (step_words.size() == 0 && wide) step_words.push_back('0);
            foreach (step_words[j]) begin
                r = step_words[j];
                r.too_wide = wide;
                r.final_flag = (j == step_words.size() - 1);
                pending_words.push_back(r);
            end
        endfunction

        function void check_word(packed_word_t got);
            packed_word_t exp_w;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                error_count++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.word !== exp_w.word) begin
                $display("%0t: word exp %h got %h", $time, exp_w.word, got.word);
                error_count++;
            end
            if (got.count !== exp_w.count) begin
                $display("%0t: count exp %0d got %0d", $time, exp_w.count, got.count);
                error_count++;
            end
            if (got.too_wide !== exp_w.too_wide) begin
                $display("%0t: too_wide exp %b got %b", $time, exp_w.too_wide,
                         got.too_wide);
                error_count++;
            end
            if (got.final_flag !== exp_w.final_flag) begin
                $display("%0t: final exp %b got %b", $time, exp_w.final_flag,
                         got.final_flag);
                error_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value
    logic        s_tlast;   // list_end
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // packed_word[31:0], values_packed[36:32]
    logic        m_tlast;   // final_word
    logic        m_tuser;   // value_too_wide

    simple9_word_packer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    word_scoreboard board;
    int  send_idle_pct;     // chance in 100 the sender skips a cycle
    int  recv_stall_pct;    // chance in 100 the receiver stalls
    int  hold_off_cycles;   // long receiver hold-off, counted by the receiver
    bit  hold_off_req;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: tready changes at the falling edge, results sampled at rising.
    initial begin
        packed_word_t got;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.word = m_tdata[31:0];
                got.count = m_tdata[36:32];
                got.final_flag = m_tlast;
                got.too_wide = m_tuser;
                board.check_word(got);
            end
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 0;
                hold_off_req = 0;
                repeat (hold_off_cycles) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until accepted; gaps are taken beforehand.
    task automatic send_item(logic [31:0] value, logic list_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= value;
        s_tlast  <= list_end;
        do @(posedge aclk); while (!s_tready);
        board.note_item(value, list_end);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        do @(negedge aclk); while (board.pending_words.size() != 0);
    endtask

    // Mostly small values so wide layouts get used; now and then big or too wide.
    function automatic logic [31:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom_range(1);
        if (pick < 60) return $urandom_range(15);
        if (pick < 75) return $urandom_range(127);
        if (pick < 85) return $urandom_range(16383);
        if (pick < 95) return $urandom & 32'h0FFF_FFFF;
        return $urandom | 32'h1000_0000 << $urandom_range(3);
    endfunction

    task automatic random_lists(int unsigned n_items);
        int unsigned sent, len, i;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
            if (len > n_items - sent) len = n_items - sent;
            for (i = 0; i < len; i++) begin
                send_item(rand_value(), (i == len - 1) || ($urandom_range(49) == 0));
                sent++;
            end
        end
    endtask

    initial begin
        int i;
        board = new();
        board.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 0;
        hold_off_cycles = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: 28 ones fill the buffer exactly and emit one 28x1 word.
        for (i = 0; i < 28; i++) send_item(32'd1, 0);
        // Too-wide value alone: error word only.
        send_item(32'hFFFF_FFFF, 0);
        // Field extremes, then a too-wide value that ends the list and flushes.
        send_item(32'h0FFF_FFFF, 0);
        send_item(32'd0, 0);
        send_item(32'd1023, 0);
        send_item(32'h1000_0000, 1);
        // List end with a too-wide value on an empty buffer: error word only.
        send_item(32'h8000_0000, 1);
        drain();
        // List end on a short list: zero padding in the last word.
        send_item(32'd3, 0);
        send_item(32'd7, 0);
        send_item(32'd0, 1);
        send_item(32'd16383, 1);
        drain();
        // Sender pauses until every word is out.

        // Long receiver hold-off while the sender keeps going.
        hold_off_cycles = 400;
        hold_off_req = 1;
        random_lists(56);

        random_lists(56);
        send_idle_pct = 59;
        random_lists(56);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 59;
        random_lists(56);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        random_lists(56);
        send_item(32'd5, 1);
        drain();
        repeat (200) @(negedge aclk);

        if (board.error_count == 0 && board.pending_words.size() == 0)
            $display("simple9_word_packer_tb: clean");
        else
            $display("simple9_word_packer_tb: errors");
        $finish;
    end

    initial begin
        #100ms;
        $display("simple9_word_packer_tb: errors");
        $finish;
    end

endmodule

// File: simple9_word_packer.f
+incdir+rtl
rtl/s9wp_pkg.sv
rtl/simple9_word_packer.sv
dv/simple9_word_packer_tb.sv
